// File: rtl/uuencode_line_encoder_assert.svh
// Assertion macros for the uuencode line encoder RTL.
// Included by modules that check their own control logic; no dependencies.
`ifndef UUENCODE_LINE_ENCODER_ASSERT_SVH
`define UUENCODE_LINE_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

`define UULE_ASSERT(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`define UULE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define UULE_ASSERT(label, clk, rst_n, cond)

`define UULE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/uule_pkg.sv
// Shared constants and the 6-bit digit encoder for the uuencode line encoder.
// No dependencies.
package uule_pkg;

  localparam int unsigned LINE_BYTES_DEF = 45;

  localparam logic [6:0] GRAVE   = 7'd96;
  localparam logic [6:0] NEWLINE = 7'd10;
  localparam logic [6:0] SPACE   = 7'd32;

  function automatic logic [6:0] enc_digit(input logic [5:0] d);
    logic [6:0] r;
    r = (d == 6'd0) ? GRAVE : ({1'b0, d} + SPACE);
    return r;
  endfunction

endpackage

// File: rtl/uule_line_mem.sv
// Line store: single write port, single read port, registered read data.
// Depends on uule_pkg.
module uule_line_mem import uule_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF,
  localparam int unsigned AddrW = $clog2(LINE_BYTES)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [LINE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/uule_ctrl.sv
// Fill counter, line emission sequencer and output register.
// Depends on uule_pkg and uuencode_line_encoder_assert.svh; drives uule_line_mem.
`include "uuencode_line_encoder_assert.svh"

module uule_ctrl import uule_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF,
  localparam int unsigned AddrW = $clog2(LINE_BYTES),
  localparam int unsigned FillW = $clog2(LINE_BYTES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             byte_valid_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [6:0]       out_char_o,
  output logic             last_of_run_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [7:0]       mem_wdata_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  logic [7:0]       mem_rdata_i
);

  localparam int unsigned IdxW = $clog2(LINE_BYTES + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_DATA,
    S_NL,
    S_TERM_G,
    S_TERM_NL
  } state_e;

  state_e           state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] n_q, n_d;
  logic             end_q, end_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       prev_q, prev_d;
  logic             out_valid_q, out_valid_d;
  logic [6:0]       out_char_q, out_char_d;
  logic             out_last_q, out_last_d;

  logic             slot_free;
  logic             accept;
  logic [7:0]       cur;
  logic [IdxW-1:0]  idx_inc;
  logic [FillW-1:0] fill_new;
  logic             line_go;
  logic             group_done;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign cur         = (idx_q < IdxW'(n_q)) ? mem_rdata_i : 8'd0;
  assign idx_inc     = idx_q + IdxW'(1);
  assign fill_new    = byte_valid_i ? (fill_q + FillW'(1)) : fill_q;
  assign line_go     = (byte_valid_i && (fill_new == FillW'(LINE_BYTES)))
                       || (end_of_data_i && (fill_new != '0));
  assign group_done  = (idx_inc >= IdxW'(n_q));

  assign mem_we_o    = accept && byte_valid_i;
  assign mem_waddr_o = fill_q[AddrW-1:0];
  assign mem_wdata_o = data_byte_i;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    n_d         = n_q;
    end_d       = end_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_inc[AddrW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          n_d   = fill_new;
          end_d = end_of_data_i;
          if (line_go) begin
            fill_d  = '0;
            state_d = S_LEN;
          end else if (end_of_data_i) begin
            fill_d  = '0;
            state_d = S_TERM_G;
          end else begin
            fill_d = fill_new;
          end
        end
      end
      S_LEN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = enc_digit(6'(n_q));
          out_last_d  = 1'b0;
          idx_d       = '0;
          phase_d     = 2'd0;
          mem_re_o    = 1'b1;
          mem_raddr_o = '0;
          state_d     = S_DATA;
        end
      end
      S_DATA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b0;
          prev_d      = cur;
          case (phase_q)
            2'd0: out_char_d = enc_digit(cur[7:2]);
            2'd1: out_char_d = enc_digit({prev_q[1:0], cur[7:4]});
            2'd2: out_char_d = enc_digit({prev_q[3:0], cur[7:6]});
            default: begin
              out_char_d = enc_digit(prev_q[5:0]);
              prev_d     = prev_q;
            end
          endcase
          phase_d = phase_q + 2'd1;
          if (phase_q == 2'd3 && group_done) begin
            state_d = S_NL;
          end else if (phase_q != 2'd2) begin
            idx_d    = idx_inc;
            mem_re_o = (idx_inc < IdxW'(LINE_BYTES));
          end
        end
      end
      S_NL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = NEWLINE;
          out_last_d  = !end_q;
          state_d     = end_q ? S_TERM_G : S_IDLE;
        end
      end
      S_TERM_G: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = GRAVE;
          out_last_d  = 1'b0;
          state_d     = S_TERM_NL;
        end
      end
      S_TERM_NL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = NEWLINE;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      n_q         <= '0;
      end_q       <= 1'b0;
      idx_q       <= '0;
      phase_q     <= 2'd0;
      prev_q      <= 8'd0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      n_q         <= n_d;
      end_q       <= end_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;

  `UULE_ASSERT(a_fill_below_line, clk_i, rst_ni, fill_q < FillW'(LINE_BYTES))
  `UULE_ASSERT(a_data_has_bytes, clk_i, rst_ni, (state_q != S_DATA) || (n_q != '0))
  `UULE_ASSERT_NEXT(a_end_starts_run, clk_i, rst_ni, accept && end_of_data_i,
                    (state_q != S_IDLE) && (fill_q == '0))
  `UULE_ASSERT_NEXT(a_idle_accept_no_read, clk_i, rst_ni, (state_q == S_IDLE) && mem_re_o,
                    1'b0)

endmodule

// File: rtl/uuencode_line_encoder.sv
// uuencode line encoder: byte input channel, character output channel.
// Bytes collect into a line store; each full line, or the partial line at
// end of data, is sent as a length character, four characters per
// three-byte group (short groups padded with zero bytes) and a newline.
// End of data adds a terminating grave accent and newline.
// Input takes one item while the encoder is idle; an item that neither
// finishes a line nor ends the data is absorbed. An item that completes a
// line of N bytes yields 4*ceil(N/3)+2 characters at one per cycle while
// not stalled (plus two more at end of data), then input reopens. The
// registered store read is issued a character ahead to keep that rate.
// Characters sit in an output register; a stall holds the sequencer and
// the store read data, and input may be taken while the final character
// still waits. last_of_run marks the final character caused by an item.
// Reset clears the fill count and sequencer; the store needs no clearing
// since bytes past the fill count of the current line are never used.
// Depends on uule_pkg, uule_ctrl and uule_line_mem.
module uuencode_line_encoder import uule_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       byte_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       last_of_run_o
);

  localparam int unsigned AddrW = $clog2(LINE_BYTES);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  uule_ctrl #(
    .LINE_BYTES(LINE_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_valid_i (byte_valid_i),
    .data_byte_i  (data_byte_i),
    .end_of_data_i(end_of_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .last_of_run_o(last_of_run_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  uule_line_mem #(
    .LINE_BYTES(LINE_BYTES)
  ) u_line_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
